@@ src/xsop_pkg.sv @@
// Shared types and constants for the x86 string operation step pipeline.
// Holds opcode and status codes, EFLAGS bit positions and the subtract result record.
// No dependencies.
package xsop_pkg;

    typedef enum logic [2:0] {
        OP_CLD     = 3'd0,
        OP_STD     = 3'd1,
        OP_MOVS    = 3'd2,
        OP_STOS    = 3'd3,
        OP_LODS    = 3'd4,
        OP_CMPS    = 3'd5,
        OP_SCAS    = 3'd6,
        OP_INVALID = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_REPEAT  = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 2;
    localparam int unsigned FLAG_AF = 4;
    localparam int unsigned FLAG_ZF = 6;
    localparam int unsigned FLAG_SF = 7;
    localparam int unsigned FLAG_DF = 10;
    localparam int unsigned FLAG_OF = 11;

    typedef struct packed {
        logic [31:0] res;
        logic        cf;
        logic        af;
        logic        sf;
        logic        of;
    } sub_t;

endpackage

@@ src/xsop_flags.sv @@
// Final EFLAGS merge for CMPS and SCAS: zero and parity from the registered difference.
// Depends on xsop_pkg for sub_t and the flag bit positions.
module xsop_flags
    import xsop_pkg::*;
(
    input  sub_t        sub,
    input  logic        sub_sel,
    input  logic [31:0] flags_in,
    output logic [31:0] flags_out,
    output logic        zf
);

    logic [31:0] merged;

    always_comb
    begin
        zf     = (sub.res == 32'd0);
        merged = flags_in;
        merged[FLAG_CF] = sub.cf;
        merged[FLAG_PF] = ~(^sub.res[7:0]);
        merged[FLAG_AF] = sub.af;
        merged[FLAG_ZF] = zf;
        merged[FLAG_SF] = sub.sf;
        merged[FLAG_OF] = sub.of;
        flags_out = sub_sel ? merged : flags_in;
    end

endmodule

@@ src/x86_string_op_step.sv @@
// Top level of the x86 string operation step: three-stage pipeline with valid and stall.
// Depends on xsop_pkg and xsop_flags.
//
//  channel | direction | handshake           | payload
//  input   | in        | in_valid / in_stall | op, wide, prefixes, pointers, count, acc, flags,
//          |           |                     | mem_a, mem_b, instr_addr
//  output  | out       | out_valid/out_stall | status, next_addr, registers, flags, write
//
// One transaction enters every cycle while in_stall is low.
// Stage 1 decodes, stage 2 does the 33-bit subtract and pointer/count adds,
// stage 3 merges flags, resolves the repeat and holds the result.
// Reset clears the stage valid bits only.
// A stage advances when it is empty or the next one advances; bubbles collapse.
module x86_string_op_step
    import xsop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic        wide,
    input  logic        rep_prefix,
    input  logic        repne_prefix,
    input  logic [31:0] src_ptr,
    input  logic [31:0] dst_ptr,
    input  logic [31:0] count_in,
    input  logic [31:0] acc_in,
    input  logic [31:0] flags_in,
    input  logic [31:0] mem_a,
    input  logic [31:0] mem_b,
    input  logic [31:0] instr_addr,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] next_addr,
    output logic [31:0] src_ptr_out,
    output logic [31:0] dst_ptr_out,
    output logic [31:0] count_out,
    output logic [31:0] acc_out,
    output logic [31:0] flags_out,
    output logic        write_en,
    output logic [31:0] write_addr,
    output logic [31:0] write_data
);

    logic move1, move2, move3;

    // stage 1
    logic        v1_reg;
    op_t         op1_reg;
    logic        wide1_reg, rep1_reg, repne1_reg, active1_reg, inv1_reg;
    logic [31:0] esi1_reg, edi1_reg, ecx1_reg, eax1_reg, fl1_reg, ma1_reg, eip1_reg;
    logic [31:0] step1_reg, opa1_reg, opb1_reg;

    // stage 2
    logic        v2_reg;
    logic        active2_reg, inv2_reg, rep2_reg, repne2_reg, cmp2_reg, wen2_reg;
    logic [31:0] esi2_reg, edi2_reg, ecx2_reg, eax2_reg, fl2_reg, eip2_reg;
    logic [31:0] waddr2_reg, wdata2_reg;
    sub_t        sub2_reg;

    // stage 3 / output
    logic        v3_reg;
    logic [1:0]  status_reg;
    logic [31:0] next_reg, esi3_reg, edi3_reg, ecx3_reg, eax3_reg, fl3_reg;
    logic        wen3_reg;
    logic [31:0] waddr3_reg, wdata3_reg;

    assign move3    = !v3_reg || !out_stall;
    assign move2    = !v2_reg || move3;
    assign move1    = !v1_reg || move2;
    assign in_stall = !move1;

    // decode
    op_t         op_d;
    logic        has_rep_d, special_d, skip_d, active_d, inv_d;
    logic [31:0] fl_d, step_d, opa_d, opb_d, mask_d;

    always_comb
    begin
        op_d      = op_t'(op);
        has_rep_d = rep_prefix || repne_prefix;
        special_d = (op_d == OP_CLD) || (op_d == OP_STD);
        skip_d    = special_d || (has_rep_d && (count_in == 32'd0));
        inv_d     = !skip_d && (op_d == OP_INVALID);
        active_d  = !skip_d && !inv_d;
        fl_d      = flags_in;
        if (op_d == OP_CLD)
        begin
            fl_d[FLAG_DF] = 1'b0;
        end
        else if (op_d == OP_STD)
        begin
            fl_d[FLAG_DF] = 1'b1;
        end
        step_d = wide ? 32'd4 : 32'd1;
        if (fl_d[FLAG_DF])
        begin
            step_d = 32'd0 - step_d;
        end
        mask_d = wide ? 32'hFFFF_FFFF : 32'h0000_00FF;
        opa_d  = ((op_d == OP_CMPS) ? mem_a : acc_in) & mask_d;
        opb_d  = ((op_d == OP_CMPS) ? mem_b : mem_a) & mask_d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (move1)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            op1_reg     <= op_d;
            wide1_reg   <= wide;
            rep1_reg    <= rep_prefix;
            repne1_reg  <= repne_prefix;
            active1_reg <= active_d;
            inv1_reg    <= inv_d;
            esi1_reg    <= src_ptr;
            edi1_reg    <= dst_ptr;
            ecx1_reg    <= count_in;
            eax1_reg    <= acc_in;
            fl1_reg     <= fl_d;
            ma1_reg     <= mem_a;
            eip1_reg    <= instr_addr;
            step1_reg   <= step_d;
            opa1_reg    <= opa_d;
            opb1_reg    <= opb_d;
        end
    end

    // subtract, pointer and count update
    logic        is_movs, is_stos, is_lods, is_cmps, is_scas, has_rep1;
    logic [32:0] diff_next;
    sub_t        sub_next;
    logic [31:0] esi_next, edi_next, ecx_next, eax_next, wdata_next, axb, top_bits;

    always_comb
    begin
        is_movs  = (op1_reg == OP_MOVS);
        is_stos  = (op1_reg == OP_STOS);
        is_lods  = (op1_reg == OP_LODS);
        is_cmps  = (op1_reg == OP_CMPS);
        is_scas  = (op1_reg == OP_SCAS);
        has_rep1 = rep1_reg || repne1_reg;

        diff_next    = {1'b0, opa1_reg} - {1'b0, opb1_reg};
        sub_next.res = wide1_reg ? diff_next[31:0] : {24'd0, diff_next[7:0]};
        sub_next.cf  = diff_next[32];
        axb          = opa1_reg ^ opb1_reg;
        top_bits     = axb & (opa1_reg ^ sub_next.res);
        sub_next.af  = axb[FLAG_AF] ^ sub_next.res[FLAG_AF];
        sub_next.sf  = wide1_reg ? sub_next.res[31] : sub_next.res[7];
        sub_next.of  = wide1_reg ? top_bits[31] : top_bits[7];

        esi_next = esi1_reg;
        edi_next = edi1_reg;
        if (active1_reg && (is_movs || is_lods || is_cmps))
        begin
            esi_next = esi1_reg + step1_reg;
        end
        if (active1_reg && (is_movs || is_stos || is_cmps || is_scas))
        begin
            edi_next = edi1_reg + step1_reg;
        end
        ecx_next = (active1_reg && has_rep1) ? ecx1_reg - 32'd1 : ecx1_reg;
        eax_next = eax1_reg;
        if (active1_reg && is_lods)
        begin
            eax_next = wide1_reg ? ma1_reg : {eax1_reg[31:8], ma1_reg[7:0]};
        end
        wdata_next = is_movs ? ma1_reg : eax1_reg;
        if (!wide1_reg)
        begin
            wdata_next = {24'd0, wdata_next[7:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (move2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move2)
        begin
            active2_reg <= active1_reg;
            inv2_reg    <= inv1_reg;
            rep2_reg    <= rep1_reg;
            repne2_reg  <= repne1_reg;
            cmp2_reg    <= active1_reg && (is_cmps || is_scas);
            wen2_reg    <= active1_reg && (is_movs || is_stos);
            esi2_reg    <= esi_next;
            edi2_reg    <= edi_next;
            ecx2_reg    <= ecx_next;
            eax2_reg    <= eax_next;
            fl2_reg     <= fl1_reg;
            eip2_reg    <= eip1_reg;
            waddr2_reg  <= edi1_reg;
            wdata2_reg  <= wdata_next;
            sub2_reg    <= sub_next;
        end
    end

    // flags merge and repeat decision
    logic [31:0] fl_next;
    logic        zf, term, repeat_next;
    logic [1:0]  status_next;

    xsop_flags u_flags (
        .sub       (sub2_reg),
        .sub_sel   (cmp2_reg),
        .flags_in  (fl2_reg),
        .flags_out (fl_next),
        .zf        (zf)
    );

    always_comb
    begin
        term        = cmp2_reg && ((rep2_reg && !zf) || (repne2_reg && zf));
        repeat_next = active2_reg && (rep2_reg || repne2_reg) &&
                      (ecx2_reg != 32'd0) && !term;
        priority if (inv2_reg)
        begin
            status_next = ST_INVALID;
        end
        else if (repeat_next)
        begin
            status_next = ST_REPEAT;
        end
        else
        begin
            status_next = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (move3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move3)
        begin
            status_reg <= status_next;
            next_reg   <= repeat_next ? eip2_reg : 32'd0;
            esi3_reg   <= esi2_reg;
            edi3_reg   <= edi2_reg;
            ecx3_reg   <= ecx2_reg;
            eax3_reg   <= eax2_reg;
            fl3_reg    <= fl_next;
            wen3_reg   <= wen2_reg;
            waddr3_reg <= wen2_reg ? waddr2_reg : 32'd0;
            wdata3_reg <= wen2_reg ? wdata2_reg : 32'd0;
        end
    end

    assign out_valid   = v3_reg;
    assign status      = status_reg;
    assign next_addr   = next_reg;
    assign src_ptr_out = esi3_reg;
    assign dst_ptr_out = edi3_reg;
    assign count_out   = ecx3_reg;
    assign acc_out     = eax3_reg;
    assign flags_out   = fl3_reg;
    assign write_en    = wen3_reg;
    assign write_addr  = waddr3_reg;
    assign write_data  = wdata3_reg;

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty stage");

    a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_REPEAT)) |-> (next_addr == 32'd0))
        else $error("resume address set without repeat");

    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_en) |-> (status != ST_INVALID))
        else $error("memory write on invalid opcode");

    a_repeat_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_REPEAT)) |-> (count_out != 32'd0))
        else $error("repeat with exhausted count");

endmodule
